// ----- design/fslm_pkg.sv -----
// Shared types and constants for the fault and stall latch monitor.
`timescale 1ns / 1ps
`default_nettype none

package fslm_pkg;

  localparam int CountW = 8;
  localparam int AxisW  = 3;
  localparam logic [CountW-1:0] CountMax = 8'hFF;
  localparam logic [CountW-1:0] ThresholdReset = 8'd3;

  typedef enum logic [2:0] {
    CMD_POLL        = 3'd0,
    CMD_MISS        = 3'd1,
    CMD_SEGMENT     = 3'd2,
    CMD_FAULT_RESET = 3'd3,
    CMD_BEGIN       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FAULT = 2'd1,
    KIND_STALL = 2'd2
  } kind_t;

  // control from the top level to the counter bank
  typedef struct packed {
    logic             update;
    logic             miss;
    logic             clear;
    logic [AxisW-1:0] axis;
  } bank_ctl_t;

  // status back from the counter bank
  typedef struct packed {
    logic              stall_raise;
    logic [CountW-1:0] count;
  } bank_sts_t;

endpackage

`default_nettype wire

// ----- design/fslm_axis_bank.sv -----
// Per-axis missed-deadline counters with stall guards.
`timescale 1ns / 1ps
`default_nettype none

module fslm_axis_bank #(
  parameter int AXIS_COUNT = 2
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire fslm_pkg::bank_ctl_t       ctl,
  input  wire logic [fslm_pkg::CountW-1:0] threshold,
  output fslm_pkg::bank_sts_t            sts
);

  logic [fslm_pkg::CountW-1:0] cnt_r   [AXIS_COUNT];
  logic [fslm_pkg::CountW-1:0] cnt_nxt [AXIS_COUNT];
  logic [AXIS_COUNT-1:0]       rep_r;
  logic [AXIS_COUNT-1:0]       rep_nxt;
  logic [AXIS_COUNT-1:0]       raise;
  logic [AXIS_COUNT-1:0]       hit;

  always_comb begin
    logic [fslm_pkg::CountW-1:0] inc;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      hit[i] = (ctl.axis == fslm_pkg::AxisW'(i));
      inc = (cnt_r[i] < fslm_pkg::CountMax) ? cnt_r[i] + 8'd1 : cnt_r[i];
      raise[i] = 1'b0;
      cnt_nxt[i] = cnt_r[i];
      rep_nxt[i] = rep_r[i];
      if (ctl.clear) begin
        cnt_nxt[i] = '0;
        rep_nxt[i] = 1'b0;
      end else if (ctl.miss && hit[i]) begin
        cnt_nxt[i] = inc;
        raise[i] = (inc >= threshold) && !rep_r[i];
        rep_nxt[i] = rep_r[i] | raise[i];
      end
    end
  end

  always_comb begin
    sts.stall_raise = |raise;
    sts.count = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      sts.count = sts.count | (hit[i] ? cnt_nxt[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= '0;
      for (int i = 0; i < AXIS_COUNT; i++) cnt_r[i] <= '0;
    end else if (ctl.update) begin
      rep_r <= rep_nxt;
      for (int i = 0; i < AXIS_COUNT; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

endmodule

`default_nettype wire

// ----- design/fault_and_stall_latch_monitor.sv -----
// Top level of the motor driver fault and stall supervisor.
//
// Each input beat is one event (poll, missed deadline, segment reset, fault
// reset, begin) and yields exactly one status beat. The block takes one beat
// per clock unless the output stalls; the status is registered in a single output
// register the cycle after acceptance, and a new beat is accepted whenever that
// register is empty or is being drained in the same cycle. The miss threshold on
// cfg_data may be written at any time the block is idle; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module fault_and_stall_latch_monitor #(
  parameter int AXIS_COUNT = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [2:0] axis, [3] fault_active
  input  wire logic [2:0]  in_tuser,   // [2:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [0] drivers_enabled, [1] faulted, [2] stalled,
                                       // [3] error_raised, [5:4] last_kind, [8:6] last_axis,
                                       // [9] last_axis_none, [17:10] last_count,
                                       // [25:18] axis_missed
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic        in_fire;
  fslm_pkg::cmd_t cmd;
  logic [2:0]  axis;
  logic        fault_in;

  logic        fault_r, fault_nxt;
  logic        stall_r, stall_nxt;
  logic        enable_r, enable_nxt;
  fslm_pkg::kind_t kind_r, kind_nxt;
  logic [2:0]  laxis_r, laxis_nxt;
  logic        lnone_r, lnone_nxt;
  logic [7:0]  lcount_r, lcount_nxt;
  logic        raised;
  logic [7:0]  thr_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  fslm_pkg::bank_ctl_t bank_ctl;
  fslm_pkg::bank_sts_t bank_sts;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cmd       = fslm_pkg::cmd_t'(in_tuser);
  assign axis      = in_tdata[2:0];
  assign fault_in  = in_tdata[3];
  assign cfg_ready = 1'b1;

  assign bank_ctl.update = in_fire;
  assign bank_ctl.miss   = (cmd == fslm_pkg::CMD_MISS);
  assign bank_ctl.clear  = (cmd == fslm_pkg::CMD_SEGMENT) ||
                           (cmd == fslm_pkg::CMD_FAULT_RESET) ||
                           (cmd == fslm_pkg::CMD_BEGIN);
  assign bank_ctl.axis   = axis;

  fslm_axis_bank #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (bank_ctl),
    .threshold (thr_r),
    .sts       (bank_sts)
  );

  always_comb begin
    fault_nxt  = fault_r;
    stall_nxt  = stall_r;
    enable_nxt = enable_r;
    kind_nxt   = kind_r;
    laxis_nxt  = laxis_r;
    lnone_nxt  = lnone_r;
    lcount_nxt = lcount_r;
    raised     = 1'b0;
    unique case (cmd)
      fslm_pkg::CMD_POLL: begin
        if (!fault_r && fault_in) begin
          enable_nxt = 1'b0;
          fault_nxt  = 1'b1;
          kind_nxt   = fslm_pkg::KIND_FAULT;
          laxis_nxt  = '0;
          lnone_nxt  = 1'b1;
          lcount_nxt = '0;
          raised     = 1'b1;
        end
      end
      fslm_pkg::CMD_MISS: begin
        if (bank_sts.stall_raise) begin
          stall_nxt  = 1'b1;
          kind_nxt   = fslm_pkg::KIND_STALL;
          laxis_nxt  = axis;
          lnone_nxt  = 1'b0;
          lcount_nxt = bank_sts.count;
          raised     = 1'b1;
        end
      end
      fslm_pkg::CMD_SEGMENT: begin
      end
      fslm_pkg::CMD_FAULT_RESET: begin
        enable_nxt = 1'b1;
        fault_nxt  = 1'b0;
        stall_nxt  = 1'b0;
      end
      fslm_pkg::CMD_BEGIN: begin
        fault_nxt  = 1'b0;
        stall_nxt  = 1'b0;
        kind_nxt   = fslm_pkg::KIND_NONE;
        laxis_nxt  = '0;
        lnone_nxt  = 1'b0;
        lcount_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r     <= 1'b0;
      stall_r     <= 1'b0;
      enable_r    <= 1'b1;
      kind_r      <= fslm_pkg::KIND_NONE;
      laxis_r     <= '0;
      lnone_r     <= 1'b0;
      lcount_r    <= '0;
      thr_r       <= fslm_pkg::ThresholdReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) thr_r <= cfg_data;
      if (in_fire) begin
        fault_r  <= fault_nxt;
        stall_r  <= stall_nxt;
        enable_r <= enable_nxt;
        kind_r   <= kind_nxt;
        laxis_r  <= laxis_nxt;
        lnone_r  <= lnone_nxt;
        lcount_r <= lcount_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {6'd0, bank_sts.count, lcount_nxt, lnone_nxt, laxis_nxt,
                     kind_nxt, raised, stall_nxt, fault_nxt, enable_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a latched fault always has the drivers off
  a_fault_disables: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |-> !enable_r)
    else $error("fault latched with drivers enabled");

  a_fault_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cmd == fslm_pkg::CMD_FAULT_RESET) |=> enable_r && !fault_r && !stall_r)
    else $error("fault reset did not clear latches");

  a_raise_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[3] |-> (out_data_r[5:4] == fslm_pkg::KIND_FAULT) ||
                                     (out_data_r[5:4] == fslm_pkg::KIND_STALL))
    else $error("error raised without error kind");

  a_fault_no_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r[5:4] == fslm_pkg::KIND_FAULT) |->
      out_data_r[9] && (out_data_r[8:6] == 3'd0))
    else $error("fault error names an axis");

  a_stall_raise_latches: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cmd == fslm_pkg::CMD_MISS) && bank_sts.stall_raise |=> stall_r)
    else $error("stall raised without latching");

endmodule

`default_nettype wire

// ----- sim/fault_and_stall_latch_monitor_tb.sv -----
// Self-checking testbench for the fault and stall latch monitor.
`timescale 1ns / 1ps

module fault_and_stall_latch_monitor_tb;

  localparam int AxisCount  = 2;
  localparam int CycleLimit = 200000;

  typedef struct {
    fslm_pkg::cmd_t cmd;
    logic [2:0]     axis;
    logic           fault;
  } event_t;

  typedef struct {
    logic       drivers_enabled;
    logic       faulted;
    logic       stalled;
    logic       error_raised;
    logic [1:0] last_kind;
    logic [2:0] last_axis;
    logic       last_axis_none;
    logic [7:0] last_count;
    logic [7:0] axis_missed;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [2:0] axis, [3] fault_active
  logic [2:0]  in_tuser = '0;   // [2:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [0] drivers_enabled, [1] faulted, [2] stalled,
                                // [3] error_raised, [5:4] last_kind, [8:6] last_axis,
                                // [9] last_axis_none, [17:10] last_count,
                                // [25:18] axis_missed
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  event_t  event_q[$];
  status_t status_due[$];
  bit      bursty = 1'b1;
  bit      in_took = 1'b0;
  int      in_gap = 0;
  int      out_gap = 0;
  int      fail_count = 0;
  int      cycles = 0;

  // supervisor shadow state
  logic [7:0]      sv_threshold = fslm_pkg::ThresholdReset;
  logic            sv_fault = 1'b0;
  logic            sv_stall = 1'b0;
  logic            sv_enable = 1'b1;
  logic [7:0]      miss_cnt[AxisCount];
  logic            stall_seen[AxisCount];
  fslm_pkg::kind_t last_kind_r = fslm_pkg::KIND_NONE;
  logic [3:0]      last_axis_r = '0;   // bit 3: no axis
  logic [7:0]      last_cnt_r = '0;

  fault_and_stall_latch_monitor #(
    .AXIS_COUNT(AxisCount)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_counts();
    for (int i = 0; i < AxisCount; i++) begin
      miss_cnt[i] = '0;
      stall_seen[i] = 1'b0;
    end
  endfunction

  function automatic status_t supervise_event(fslm_pkg::cmd_t cmd, logic [2:0] axis,
                                              logic fault);
    status_t st;
    logic    ax_ok;
    logic    raised;
    ax_ok = axis < AxisCount;
    raised = 1'b0;
    case (cmd)
      fslm_pkg::CMD_POLL: begin
        if (!sv_fault && fault) begin
          sv_enable = 1'b0;
          sv_fault = 1'b1;
          last_kind_r = fslm_pkg::KIND_FAULT;
          last_axis_r = 4'b1000;
          last_cnt_r = '0;
          raised = 1'b1;
        end
      end
      fslm_pkg::CMD_MISS: begin
        if (ax_ok) begin
          if (miss_cnt[axis] != fslm_pkg::CountMax) miss_cnt[axis] = miss_cnt[axis] + 8'd1;
          if (miss_cnt[axis] >= sv_threshold && !stall_seen[axis]) begin
            stall_seen[axis] = 1'b1;
            sv_stall = 1'b1;
            last_kind_r = fslm_pkg::KIND_STALL;
            last_axis_r = {1'b0, axis};
            last_cnt_r = miss_cnt[axis];
            raised = 1'b1;
          end
        end
      end
      fslm_pkg::CMD_SEGMENT: clear_counts();
      fslm_pkg::CMD_FAULT_RESET: begin
        sv_enable = 1'b1;
        sv_fault = 1'b0;
        sv_stall = 1'b0;
        clear_counts();
      end
      fslm_pkg::CMD_BEGIN: begin
        sv_fault = 1'b0;
        sv_stall = 1'b0;
        clear_counts();
        last_kind_r = fslm_pkg::KIND_NONE;
        last_axis_r = '0;
        last_cnt_r = '0;
      end
      default: ;
    endcase
    st.drivers_enabled = sv_enable;
    st.faulted = sv_fault;
    st.stalled = sv_stall;
    st.error_raised = raised;
    st.last_kind = last_kind_r;
    st.last_axis = last_axis_r[3] ? 3'd0 : last_axis_r[2:0];
    st.last_axis_none = last_axis_r[3];
    st.last_count = last_cnt_r;
    st.axis_missed = '0;
    if (ax_ok) st.axis_missed = miss_cnt[axis];
    return st;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // input driver
  always @(negedge clk) begin : drive_in
    event_t ev;
    logic   nv;
    if (rst_n && !(in_tvalid && !in_took)) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 3);
      end else if (event_q.size() != 0) begin
        ev = event_q.pop_front();
        in_tdata <= {4'b0, ev.fault, ev.axis};
        in_tuser <= ev.cmd;
        nv = 1'b1;
      end
      in_tvalid <= nv;
    end
  end

  // result ready driver
  always @(negedge clk) begin : drive_out
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (bursty && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predicts on input beats, checks result beats
  always @(posedge clk) begin : watch
    status_t st;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
    in_took = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_due.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        st = status_due.pop_front();
        check_field("drivers_enabled", 32'(st.drivers_enabled), 32'(out_tdata[0]));
        check_field("faulted", 32'(st.faulted), 32'(out_tdata[1]));
        check_field("stalled", 32'(st.stalled), 32'(out_tdata[2]));
        check_field("error_raised", 32'(st.error_raised), 32'(out_tdata[3]));
        check_field("last_kind", 32'(st.last_kind), 32'(out_tdata[5:4]));
        check_field("last_axis", 32'(st.last_axis), 32'(out_tdata[8:6]));
        check_field("last_axis_none", 32'(st.last_axis_none), 32'(out_tdata[9]));
        check_field("last_count", 32'(st.last_count), 32'(out_tdata[17:10]));
        check_field("axis_missed", 32'(st.axis_missed), 32'(out_tdata[25:18]));
      end
    end
    if (in_took) status_due.push_back(supervise_event(fslm_pkg::cmd_t'(in_tuser),
                                                      in_tdata[2:0], in_tdata[3]));
  end

  task automatic push_event(fslm_pkg::cmd_t cmd, int axis, bit fault);
    event_t ev;
    ev.cmd = cmd;
    ev.axis = 3'(axis);
    ev.fault = fault;
    event_q.push_back(ev);
  endtask

  task automatic push_random(int n);
    int pick;
    int axis;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) axis = $urandom_range(AxisCount, 7);
      else axis = $urandom_range(0, AxisCount - 1);
      if (pick < 50) push_event(fslm_pkg::CMD_MISS, axis, 1'($urandom_range(0, 1)));
      else if (pick < 75) push_event(fslm_pkg::CMD_POLL, axis, $urandom_range(0, 3) == 0);
      else if (pick < 84) push_event(fslm_pkg::CMD_SEGMENT, axis, 1'($urandom_range(0, 1)));
      else if (pick < 92) push_event(fslm_pkg::CMD_FAULT_RESET, axis,
                                     1'($urandom_range(0, 1)));
      else push_event(fslm_pkg::CMD_BEGIN, axis, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    while (event_q.size() != 0 || in_tvalid || status_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sv_threshold = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clear_counts();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset threshold of 3
    push_event(fslm_pkg::CMD_POLL, 0, 0);
    push_event(fslm_pkg::CMD_POLL, 0, 1);
    push_event(fslm_pkg::CMD_POLL, 1, 1);         // fault while faulted
    push_event(fslm_pkg::CMD_MISS, 0, 0);
    push_event(fslm_pkg::CMD_MISS, 0, 1);
    push_event(fslm_pkg::CMD_MISS, 0, 0);         // reaches threshold
    push_event(fslm_pkg::CMD_MISS, 0, 0);         // already reported
    push_event(fslm_pkg::CMD_MISS, 7, 0);         // out of range, ignored
    push_event(fslm_pkg::CMD_POLL, 5, 0);         // query out of range
    push_event(fslm_pkg::CMD_MISS, 1, 0);
    push_event(fslm_pkg::CMD_SEGMENT, 1, 0);      // stall latch kept
    push_event(fslm_pkg::CMD_MISS, 1, 0);
    push_event(fslm_pkg::CMD_FAULT_RESET, 0, 0);
    push_event(fslm_pkg::CMD_POLL, 0, 0);
    push_event(fslm_pkg::CMD_MISS, 1, 0);
    push_event(fslm_pkg::CMD_MISS, 1, 0);
    push_event(fslm_pkg::CMD_MISS, 1, 0);
    push_event(fslm_pkg::CMD_BEGIN, 0, 0);
    push_event(fslm_pkg::CMD_POLL, 6, 1);
    push_event(fslm_pkg::CMD_BEGIN, 3, 1);        // enable line stays low
    push_event(fslm_pkg::CMD_FAULT_RESET, 4, 1);
    push_event(fslm_pkg::CMD_MISS, 2, 1);
    drain();

    write_threshold(8'd1);
    push_random(200);
    drain();

    // saturation with the top threshold
    write_threshold(8'd255);
    push_event(fslm_pkg::CMD_FAULT_RESET, 0, 0);
    for (int i = 0; i < 262; i++) begin
      if ($urandom_range(0, 15) == 0) push_event(fslm_pkg::CMD_POLL, $urandom_range(0, 7), 0);
      push_event(fslm_pkg::CMD_MISS, 0, 1'($urandom_range(0, 1)));
    end
    push_event(fslm_pkg::CMD_MISS, 1, 0);
    push_event(fslm_pkg::CMD_POLL, 1, 0);
    drain();

    write_threshold(8'($urandom_range(2, 8)));
    push_random(250);
    drain();

    write_threshold(8'd3);
    bursty = 1'b0;
    push_random(100);
    drain();
    repeat (5) @(posedge clk);

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
